FILE: src/ura_pkg.sv
// Shared types, constants and helpers for the ultrasonic range alarm.
package ura_pkg;

  localparam int DIST_W     = 16;
  localparam int THR_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic [15:0]       SCALE_RESET     = 16'd1835;  // about 0.028 in Q0.16
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd100;

  // Input word kinds
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_BYTE = 1'b1;

  localparam logic [7:0]        ASCII_COLON  = 8'h3A;
  localparam logic [7:0]        ASCII_ZERO   = 8'd48;
  localparam logic [THR_W-1:0]  DIGIT_OFFSET = 16'(ASCII_ZERO * 111);

  localparam logic [DIST_W-1:0] DIST_MAX    = 16'hFFFF;
  localparam logic [DIST_W-1:0] BELOW_LIMIT = 16'd100;

  // Reciprocal constants: n/100 for 16-bit n, r/10 for r below 1024
  localparam logic [16:0] DIV100_MUL   = 17'd83887;
  localparam int          DIV100_SHIFT = 23;
  localparam logic [7:0]  DIV10_MUL    = 8'd205;
  localparam int          DIV10_SHIFT  = 11;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              near_alarm;
    logic              blink;
    logic              below_hundred;
    logic [7:0]        display_byte;
  } res_t;

  // Three ASCII digits to a threshold, modulo 2^16
  function automatic logic [THR_W-1:0] frame_threshold(input logic [7:0] d1,
                                                       input logic [7:0] d2,
                                                       input logic [7:0] d3);
    logic [THR_W-1:0] a;
    logic [THR_W-1:0] b;
    logic [THR_W-1:0] c;
    a = {8'd0, d1};
    b = {8'd0, d2};
    c = {8'd0, d3};
    return (a << 6) + (a << 5) + (a << 2) + (b << 3) + (b << 1) + c - DIGIT_OFFSET;
  endfunction

endpackage

FILE: src/ura_if.sv
// Valid/ready channel interfaces for the input and result words.
interface ura_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic       echo_level;
  logic [7:0] rx_byte;

  modport source(output valid, output cmd, output echo_level, output rx_byte, input ready);
  modport sink(input valid, input cmd, input echo_level, input rx_byte, output ready);
endinterface

interface ura_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance;
  logic        near_alarm;
  logic        blink;
  logic        below_hundred;
  logic [7:0]  display_byte;

  modport source(output valid, output distance, output near_alarm, output blink,
                 output below_hundred, output display_byte, input ready);
  modport sink(input valid, input distance, input near_alarm, input blink,
               input below_hundred, input display_byte, output ready);
endinterface

FILE: src/ura_dist.sv
// Measurement pipeline: scale, saturate, compare, blink and BCD display.
module ura_dist
  import ura_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  output logic                  free,
  input  logic [COUNT_BITS-1:0] count,
  input  logic [15:0]           scale,
  input  logic [THR_W-1:0]      thr,
  output logic                  res_valid,
  input  logic                  res_ready,
  output res_t                  res
);

  localparam int PROD_W = COUNT_BITS + 16;
  localparam int PW     = (COUNT_BITS > 16) ? COUNT_BITS : 16;
  localparam int QPW    = 33;

  // stage 1: scaled count
  logic                  s1_valid;
  logic [COUNT_BITS-1:0] s1_prod;
  logic [THR_W-1:0]      s1_thr;
  // stage 2: distance and hundreds
  logic                  s2_valid;
  logic [DIST_W-1:0]     s2_dist;
  logic                  s2_near;
  logic                  s2_blink;
  logic                  s2_below;
  logic [9:0]            s2_q;
  // blink state
  logic                  blink_state;

  logic                  out_free;
  logic                  s2_free;
  logic                  s2_go;
  logic                  s1_go;

  logic [PROD_W-1:0]     prod;
  logic [PW-1:0]         p_ext;
  logic [DIST_W-1:0]     dist_sat;
  logic                  near;
  logic                  blink_next;
  logic [QPW-1:0]        q_prod;

  logic [15:0]           r_full;
  logic [6:0]            r;
  logic [14:0]           t_prod;
  logic [3:0]            tens;
  logic [6:0]            units_full;
  logic [3:0]            units;
  logic [13:0]           hi_sum;
  logic [7:0]            display;

  assign out_free = !res_valid || res_ready;
  assign s2_go    = s2_valid && out_free;
  assign s2_free  = !s2_valid || out_free;
  assign s1_go    = s1_valid && s2_free;
  assign free     = !s1_valid || s2_free;

  assign prod = PROD_W'(count) * PROD_W'(scale);

  always_comb begin
    p_ext      = PW'(s1_prod);
    dist_sat   = (p_ext > PW'(DIST_MAX)) ? DIST_MAX : p_ext[15:0];
    near       = dist_sat < s1_thr;
    blink_next = near ? 1'b0 : !blink_state;
    q_prod     = QPW'(dist_sat) * QPW'(DIV100_MUL);
  end

  always_comb begin
    r_full     = s2_dist - 16'({6'd0, s2_q} * 16'd100);
    r          = r_full[6:0];
    t_prod     = 15'(r) * 15'(DIV10_MUL);
    tens       = t_prod[DIV10_SHIFT +: 4];
    units_full = r - 7'({3'd0, tens} * 7'd10);
    units      = units_full[3:0];
    hi_sum     = {s2_q, 4'd0} + 14'(tens);
    display    = s2_below ? {tens, units} : hi_sum[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      res_valid   <= 1'b0;
      blink_state <= 1'b0;
    end else begin
      if (free) begin
        s1_valid <= load;
      end
      if (s2_free) begin
        s2_valid <= s1_go;
      end
      if (out_free) begin
        res_valid <= s2_go;
      end
      if (s1_go) begin
        blink_state <= blink_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      s1_prod <= prod[16 +: COUNT_BITS];
      s1_thr  <= thr;
    end
    if (s1_go) begin
      s2_dist  <= dist_sat;
      s2_near  <= near;
      s2_blink <= blink_next;
      s2_below <= dist_sat < BELOW_LIMIT;
      s2_q     <= q_prod[DIV100_SHIFT +: 10];
    end
    if (s2_go) begin
      res.distance      <= s2_dist;
      res.near_alarm    <= s2_near;
      res.blink         <= s2_blink;
      res.below_hundred <= s2_below;
      res.display_byte  <= display;
    end
  end

endmodule

FILE: src/ultrasonic_range_alarm_core.sv
// Ultrasonic range alarm: echo pulse timing, serial threshold frames and result pipeline.
//
// item channel: one word per timer tick (cmd low, echo_level sampled) or per
// received serial byte (cmd high, rx_byte). result channel: one word for each
// falling edge of the echo, carrying distance, near alarm, blink, range flag
// and the BCD display byte.
// A word is taken every cycle while item.ready is high. A falling-edge word
// passes through the three result registers in order: product (loaded on
// the edge that takes it), distance/hundreds, display; a stall can hold it in
// any of them. Ticks and serial bytes that give no result update the counters
// and frame state in the cycle they are taken.
// A stalled result holds in the output register; the pipeline behind it keeps
// filling, and item.ready drops only once all three stages hold a word.
// Write port: wr_index 0 sets the scale (Q0.16), 1 sets the threshold and
// loads it as active at once; write only while idle.
// Reset clears the count, blink, frame state and pending flag, loads scale
// 1835 and threshold 100, and empties the pipeline.
module ultrasonic_range_alarm_core
  import ura_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  ura_in_if.sink                item,
  ura_out_if.source             result,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  typedef enum logic [1:0] {
    FRAME_WAIT,
    FRAME_D1,
    FRAME_D2,
    FRAME_D3
  } frame_pos_t;

  frame_pos_t            frame_position;
  logic                  echo_was_high;
  logic [COUNT_BITS-1:0] pulse_ticks;
  logic [THR_W-1:0]      active_threshold;
  logic                  threshold_pending;
  logic [THR_W-1:0]      pending_threshold;
  logic [7:0]            digit_hi;
  logic [7:0]            digit_mid;
  logic [15:0]           scale_q16;

  logic                  accept;
  logic                  tick;
  logic                  fall;
  logic                  take_byte;
  logic                  pipe_free;
  res_t                  res;

  assign accept    = item.valid && item.ready;
  assign tick      = (item.cmd == CMD_TICK);
  assign fall      = accept && tick && !item.echo_level && echo_was_high;
  assign take_byte = accept && (item.cmd == CMD_BYTE) && !threshold_pending;
  assign item.ready = pipe_free;

  ura_dist #(
    .COUNT_BITS(COUNT_BITS)
  ) u_dist (
    .clk      (clk),
    .rst      (rst),
    .load     (fall),
    .free     (pipe_free),
    .count    (pulse_ticks),
    .scale    (scale_q16),
    .thr      (active_threshold),
    .res_valid(result.valid),
    .res_ready(result.ready),
    .res      (res)
  );

  assign result.distance      = res.distance;
  assign result.near_alarm    = res.near_alarm;
  assign result.blink         = res.blink;
  assign result.below_hundred = res.below_hundred;
  assign result.display_byte  = res.display_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= FRAME_WAIT;
      echo_was_high     <= 1'b0;
      pulse_ticks       <= '0;
      active_threshold  <= THRESHOLD_RESET;
      threshold_pending <= 1'b0;
      scale_q16         <= SCALE_RESET;
    end else begin
      if (accept && tick) begin
        if (item.echo_level) begin
          // first high tick restarts the count at one
          pulse_ticks   <= echo_was_high ? pulse_ticks + 1'b1 : COUNT_BITS'(1);
          echo_was_high <= 1'b1;
        end else begin
          echo_was_high <= 1'b0;
        end
      end
      // pending threshold applies once this measurement has taken the old one
      if (fall && threshold_pending) begin
        active_threshold  <= pending_threshold;
        threshold_pending <= 1'b0;
      end
      if (take_byte) begin
        case (frame_position)
          FRAME_WAIT: begin
            if (item.rx_byte == ASCII_COLON) begin
              frame_position <= FRAME_D1;
            end
          end
          FRAME_D1: frame_position <= FRAME_D2;
          FRAME_D2: frame_position <= FRAME_D3;
          FRAME_D3: begin
            frame_position    <= FRAME_WAIT;
            threshold_pending <= 1'b1;
          end
          default: frame_position <= FRAME_WAIT;
        endcase
      end
      if (wr_en) begin
        case (wr_index)
          CFG_SCALE:     scale_q16 <= wr_data[15:0];
          CFG_THRESHOLD: active_threshold <= {6'd0, wr_data[9:0]};
          default: ;
        endcase
      end
    end
  end

  // frame digits and the threshold they spell
  always_ff @(posedge clk) begin
    if (take_byte) begin
      case (frame_position)
        FRAME_D1: digit_hi  <= item.rx_byte;
        FRAME_D2: digit_mid <= item.rx_byte;
        FRAME_D3: pending_threshold <= frame_threshold(digit_hi, digit_mid, item.rx_byte);
        default: ;
      endcase
    end
  end

endmodule
